FILE: src/bmms_pkg.sv
// ----------------------------------------------------------------------------
// bmms_pkg
// Shared types, register codes and value-order helpers of the block min/max
// sampler.
// ----------------------------------------------------------------------------
package bmms_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int COORD_W    = 16;
	localparam int VALUE_W    = 64;
	localparam int FACTOR_W   = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FACTOR = 2'd0,
		REG_MODE   = 2'd1,
		REG_KIND   = 2'd2,
		REG_LEFT   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		MODE_MIN = 1'b0,
		MODE_MAX = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		KIND_SINT  = 2'd0,
		KIND_COLOR = 2'd1,
		KIND_F32   = 2'd2,
		KIND_F64   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		mode_t               mode;
		kind_t               kind;
		logic [COORD_W-1:0]  left;
	} cfg_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} entry_t;

	typedef struct packed {
		logic               take;
		logic               flush;
		logic [VALUE_W-1:0] value;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} cmd_t;

	function automatic logic [VALUE_W-1:0] keep_bits(logic [VALUE_W-1:0] v, kind_t k);
		logic [VALUE_W-1:0] r;
		if (k == KIND_COLOR || k == KIND_F32) begin
			r = {32'd0, v[31:0]};
		end else begin
			r = v;
		end
		return r;
	endfunction

	// maps stored bits to a key whose unsigned order is the value order
	function automatic logic [VALUE_W-1:0] order_key(logic [VALUE_W-1:0] v, kind_t k);
		logic [31:0]        b;
		logic [VALUE_W-1:0] key;
		b = v[31:0];
		unique case (k)
			KIND_SINT: begin
				key = {~v[63], v[62:0]};
			end
			KIND_COLOR: begin
				key = {32'd0, b};
			end
			KIND_F32: begin
				if (b[30:0] == 31'd0) begin
					key = 64'h0000_0000_8000_0000;
				end else if (b[31]) begin
					key = {32'd0, ~b};
				end else begin
					key = {32'd0, 1'b1, b[30:0]};
				end
			end
			KIND_F64: begin
				if (v[62:0] == 63'd0) begin
					key = 64'h8000_0000_0000_0000;
				end else if (v[63]) begin
					key = ~v;
				end else begin
					key = {1'b1, v[62:0]};
				end
			end
		endcase
		return key;
	endfunction

endpackage

FILE: src/bmms_if.sv
// ----------------------------------------------------------------------------
// bmms_if
// Valid/ready channels of the block min/max sampler: configuration writes,
// pixel input and block sample output.
// ----------------------------------------------------------------------------
interface bmms_cfg_if import bmms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface bmms_pix_if import bmms_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic [VALUE_W-1:0] pixel_value;
	logic               row_end;
	logic               object_end;

	modport source (output valid, output column, output row, output pixel_value,
		output row_end, output object_end, input ready);
	modport sink (input valid, input column, input row, input pixel_value,
		input row_end, input object_end, output ready);
endinterface

interface bmms_smp_if import bmms_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] sample_value;
	logic [COORD_W-1:0] sample_column;
	logic [COORD_W-1:0] sample_row;
	logic               last_of_run;

	modport source (output valid, output sample_value, output sample_column,
		output sample_row, output last_of_run, input ready);
	modport sink (input valid, input sample_value, input sample_column,
		input sample_row, input last_of_run, output ready);
endinterface

FILE: src/block_min_max_sampler.sv
// ----------------------------------------------------------------------------
// block_min_max_sampler
// Min or max pooling with first-position argmax over square pixel blocks.
//
//   channel  dir  handshake      payload
//   cfg      in   valid/ready    index, data (register write)
//   pixel    in   valid/ready    column, row, pixel_value, row_end, object_end
//   sample   out  valid/ready    sample_value, sample_column, sample_row,
//                                last_of_run
//
// A pixel in the column range of the block store passes accept, the divider
// steps in F_IDX and the queue push; a pixel outside it skips the divider
// steps. A row end that is not an object end adds the row-modulo test in
// F_ROW on the shared radix-4 remainder unit.
// The back writes an unseen block at once and updates a seen block by read,
// compare and write; a flush walks the seen flags one a cycle, waiting in B_EMIT for the sample output.
// A write to sample_factor or left_column holds pixel ready low while the origin is recomputed.
// Reset clears the seen flags at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module block_min_max_sampler import bmms_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	bmms_cfg_if.sink   cfg,
	bmms_pix_if.sink   pixel,
	bmms_smp_if.source sample
);

	localparam int IDX_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_W         = $bits(cmd_t) + IDX_W;

	cfg_t             cfg_cur;
	logic             push_valid, push_ready, pop_valid, pop_ready;
	cmd_t             cmd_f, cmd_b;
	logic [IDX_W-1:0] idx_f, idx_b;
	logic [Q_W-1:0]   push_data, pop_data;

	bmms_front #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pixel     (pixel),
		.cfg_cur   (cfg_cur),
		.cmd_valid (push_valid),
		.cmd_ready (push_ready),
		.cmd       (cmd_f),
		.cmd_idx   (idx_f)
	);

	assign push_data = {cmd_f, idx_f};

	bmms_fifo #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign {cmd_b, idx_b} = pop_data;

	bmms_back #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_cur   (cfg_cur),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (cmd_b),
		.cmd_idx   (idx_b),
		.sample    (sample)
	);

	// origin recompute blocks pixel input
	a_origin_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && (cfg.index == REG_FACTOR || cfg.index == REG_LEFT)
		|=> !pixel.ready)
		else $error("pixel ready during origin recompute");

	// one pixel in the front at a time
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> !pixel.ready)
		else $error("front took a pixel while busy");

	// a pushed command is visible to the back
	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_ready |=> pop_valid)
		else $error("queue lost a command");

endmodule

FILE: src/bmms_ram.sv
// ----------------------------------------------------------------------------
// bmms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/bmms_fifo.sv
// ----------------------------------------------------------------------------
// bmms_fifo
// Short command queue between the classifying front and the block-store back.
// ----------------------------------------------------------------------------
module bmms_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: src/bmms_front.sv
// ----------------------------------------------------------------------------
// bmms_front
// Configuration registers and pixel classification: block origin, block
// column index and block-row close test through a shared radix-4 remainder
// unit, then one command per pixel into the queue.
// ----------------------------------------------------------------------------
module bmms_front import bmms_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	bmms_cfg_if.sink         cfg,
	bmms_pix_if.sink         pixel,
	output cfg_t             cfg_cur,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cmd_t             cmd,
	output logic [IDX_W-1:0] cmd_idx
);

	localparam int STEPS     = 2 * ((IDX_W + 1) / 2);
	localparam int PAIRS     = STEPS / 2;
	localparam int ROW_PAIRS = 9;
	localparam int ORG_PAIRS = 8;

	typedef enum logic [2:0] {
		F_IDLE,
		F_ORGLD,
		F_ORG,
		F_IDX,
		F_ROW,
		F_PUSH
	} front_state_t;

	front_state_t             state_q, state_d;
	cfg_t                     cfg_q;
	logic [COORD_W-1:0]       origin_q;
	logic [FACTOR_W-1:0]      f_eff;
	logic [FACTOR_W-1:0]      rem_q, rem_next;
	logic [17:0]              shf_q, shf_next;
	logic [STEPS-1:0]         quo_q, quo_next, quo_fin;
	logic [STEPS+1:0]         quo_x;
	logic [3:0]               cnt_q;
	logic [FACTOR_W:0]        fz, t1, t2, r1, r2;
	logic                     b1, b2;
	logic                     inrange_q, take_q, flush_q;
	logic [IDX_W-1:0]         idx_q;
	logic [COORD_W-1:0]       col_q, row_q;
	logic [VALUE_W-1:0]       val_q;
	logic                     row_end_q, obj_end_q;
	logic [COORD_W:0]         row_plus;
	logic [COORD_W-1:0]       col_off, col_off_hi;
	logic [16:0]              lim;
	logic                     in_range;
	logic                     pix_acc, cfg_acc, cfg_org;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid;
	assign cfg_org   = cfg_acc && (cfg.index == REG_FACTOR || cfg.index == REG_LEFT);
	assign pix_acc   = pixel.valid && pixel.ready;
	assign cfg_cur   = cfg_q;

	assign f_eff = (cfg_q.factor == '0) ? FACTOR_W'(1) : cfg_q.factor;
	assign fz    = {1'b0, f_eff};

	// two restoring steps per cycle
	assign t1       = {rem_q, shf_q[17]};
	assign b1       = (t1 >= fz);
	assign r1       = b1 ? (t1 - fz) : t1;
	assign t2       = {r1[FACTOR_W-1:0], shf_q[16]};
	assign b2       = (t2 >= fz);
	assign r2       = b2 ? (t2 - fz) : t2;
	assign rem_next = r2[FACTOR_W-1:0];
	assign shf_next = {shf_q[15:0], 2'b00};
	assign quo_x    = {quo_q, b1, b2};
	assign quo_next = quo_x[STEPS-1:0];
	assign quo_fin  = (cnt_q == 4'd1) ? quo_next : quo_q;

	assign col_off    = pixel.column - origin_q;
	assign col_off_hi = col_off >> STEPS;
	assign lim        = 17'(f_eff) << STEPS;
	assign in_range   = (pixel.column >= origin_q) && ({1'b0, col_off} < lim);
	assign row_plus   = {1'b0, row_q} + 17'd1;

	always_comb begin
		state_d     = state_q;
		pixel.ready = 1'b0;
		cmd_valid   = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				pixel.ready = !cfg.valid;
				if (pix_acc) begin
					state_d = F_IDX;
				end
			end
			F_ORGLD: begin
				state_d = F_ORG;
			end
			F_ORG: begin
				if (cnt_q == 4'd1) begin
					state_d = F_IDLE;
				end
			end
			F_IDX: begin
				if (cnt_q <= 4'd1) begin
					state_d = (row_end_q && !obj_end_q) ? F_ROW : F_PUSH;
				end
			end
			F_ROW: begin
				if (cnt_q == 4'd1) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				cmd_valid = 1'b1;
				if (cmd_ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
		if (cfg_org) begin
			state_d = F_ORGLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			cfg_q    <= '{factor: FACTOR_W'(1), mode: MODE_MIN, kind: KIND_SINT, left: '0};
			origin_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				unique case (cfg.index)
					REG_FACTOR: cfg_q.factor <= cfg.data[FACTOR_W-1:0];
					REG_MODE:   cfg_q.mode   <= mode_t'(cfg.data[0]);
					REG_KIND:   cfg_q.kind   <= kind_t'(cfg.data[1:0]);
					REG_LEFT:   cfg_q.left   <= cfg.data[COORD_W-1:0];
				endcase
			end
			if (state_q == F_ORG && cnt_q == 4'd1) begin
				origin_q <= cfg_q.left - COORD_W'(rem_next);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (pix_acc) begin
					col_q     <= pixel.column;
					row_q     <= pixel.row;
					val_q     <= keep_bits(pixel.pixel_value, cfg_q.kind);
					row_end_q <= pixel.row_end;
					obj_end_q <= pixel.object_end;
					inrange_q <= in_range;
					rem_q     <= col_off_hi[FACTOR_W-1:0];
					shf_q     <= {col_off[STEPS-1:0], {(18 - STEPS){1'b0}}};
					quo_q     <= '0;
					cnt_q     <= in_range ? 4'(PAIRS) : 4'd0;
				end
			end
			F_ORGLD: begin
				rem_q <= '0;
				shf_q <= {cfg_q.left, 2'b00};
				cnt_q <= 4'(ORG_PAIRS);
			end
			F_ORG: begin
				rem_q <= rem_next;
				shf_q <= shf_next;
				cnt_q <= cnt_q - 4'd1;
			end
			F_IDX: begin
				if (cnt_q > 4'd1) begin
					rem_q <= rem_next;
					shf_q <= shf_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q - 4'd1;
				end else begin
					take_q  <= inrange_q && (32'(quo_fin) < 32'(MAX_BLOCKS));
					idx_q   <= quo_fin[IDX_W-1:0];
					flush_q <= obj_end_q;
					rem_q   <= '0;
					shf_q   <= {1'b0, row_plus};
					cnt_q   <= 4'(ROW_PAIRS);
				end
			end
			F_ROW: begin
				rem_q <= rem_next;
				shf_q <= shf_next;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					flush_q <= (rem_next == '0);
				end
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	assign cmd.take   = take_q;
	assign cmd.flush  = flush_q;
	assign cmd.value  = val_q;
	assign cmd.column = col_q;
	assign cmd.row    = row_q;
	assign cmd_idx    = idx_q;

endmodule

FILE: src/bmms_back.sv
// ----------------------------------------------------------------------------
// bmms_back
// Block store update (read, compare, write) and flush walk over the seen
// flags, with a registered sample output.
// ----------------------------------------------------------------------------
module bmms_back import bmms_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg_cur,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	input  logic [IDX_W-1:0] cmd_idx,
	bmms_smp_if.source       sample
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_UPD,
		B_WALK,
		B_EMIT
	} back_state_t;

	back_state_t           state_q, state_d;
	cmd_t                  cmd_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [MAX_BLOCKS-1:0] seen_q;
	logic [MAX_BLOCKS-1:0] ptr_mask;
	logic                  last_q;
	logic                  ram_we, ram_re;
	logic [IDX_W-1:0]      ram_waddr, ram_raddr;
	entry_t                wr_entry, rd_entry;
	logic [VALUE_W-1:0]    key_new, key_old;
	logic                  better;
	logic                  set_en, clr_en, ptr_clr, ptr_inc, out_load, cap;
	logic                  out_valid_q;
	entry_t                out_entry_q;
	logic                  out_last_q;

	assign key_new  = order_key(cmd_q.value, cfg_cur.kind);
	assign key_old  = order_key(rd_entry.value, cfg_cur.kind);
	assign better   = (cfg_cur.mode == MODE_MAX) ? (key_new > key_old) : (key_new < key_old);
	assign ptr_mask = MAX_BLOCKS'(1) << ptr_q;

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = cmd_idx;
		ram_raddr = cmd_idx;
		wr_entry  = '{value: cmd.value, column: cmd.column, row: cmd.row};
		set_en    = 1'b0;
		clr_en    = 1'b0;
		ptr_clr   = 1'b0;
		ptr_inc   = 1'b0;
		out_load  = 1'b0;
		cap       = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				cmd_ready = 1'b1;
				ptr_clr   = 1'b1;
				if (cmd_valid) begin
					cap = 1'b1;
					if (cmd.take && seen_q[cmd_idx]) begin
						ram_re  = 1'b1;
						state_d = B_UPD;
					end else begin
						if (cmd.take) begin
							ram_we = 1'b1;
							set_en = 1'b1;
						end
						if (cmd.flush) begin
							state_d = B_WALK;
						end
					end
				end
			end
			B_UPD: begin
				ram_waddr = idx_q;
				wr_entry  = '{value: cmd_q.value, column: cmd_q.column, row: cmd_q.row};
				ram_we    = better;
				state_d   = cmd_q.flush ? B_WALK : B_IDLE;
			end
			B_WALK: begin
				ram_raddr = ptr_q;
				if (seen_q == '0) begin
					state_d = B_IDLE;
				end else if (seen_q[ptr_q]) begin
					ram_re  = 1'b1;
					clr_en  = 1'b1;
					state_d = B_EMIT;
				end else begin
					ptr_inc = 1'b1;
				end
			end
			B_EMIT: begin
				if (!out_valid_q || sample.ready) begin
					out_load = 1'b1;
					if (last_q) begin
						state_d = B_IDLE;
					end else begin
						ptr_inc = 1'b1;
						state_d = B_WALK;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			seen_q      <= '0;
			ptr_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_en) begin
				seen_q[cmd_idx] <= 1'b1;
			end
			if (clr_en) begin
				seen_q[ptr_q] <= 1'b0;
				last_q        <= ((seen_q & ~ptr_mask) == '0);
			end
			if (ptr_clr) begin
				ptr_q <= '0;
			end else if (ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (sample.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			cmd_q <= cmd;
			idx_q <= cmd_idx;
		end
		if (out_load) begin
			out_entry_q <= rd_entry;
			out_last_q  <= last_q;
		end
	end

	bmms_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_BLOCKS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	assign sample.valid         = out_valid_q;
	assign sample.sample_value  = out_entry_q.value;
	assign sample.sample_column = out_entry_q.column;
	assign sample.sample_row    = out_entry_q.row;
	assign sample.last_of_run   = out_last_q;

endmodule

FILE: test/block_min_max_sampler_test.sv
// ----------------------------------------------------------------------------
// block_min_max_sampler_test
// Self-checking bench for the block min/max sampler. A directed set of pixels
// covers the edges of the block grid, the float orderings and empty flushes.
// Random objects and noise pixels then run under a range of register settings.
// Every accepted pixel is pooled into a local copy of the block store, and each
// sample transfer is checked against the oldest predicted block.
// ----------------------------------------------------------------------------
module block_min_max_sampler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bmms_pkg::*;

	localparam int STORE_DEPTH  = 64;
	localparam int DRAIN_CYCLES = 160;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 350;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [VALUE_W-1:0] value;
		logic               row_end;
		logic               object_end;
	} pixel_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               last_of_run;
	} block_sample_t;

	logic clk;
	logic arst_n;

	bmms_cfg_if cfg ();
	bmms_pix_if pix ();
	bmms_smp_if smp ();

	block_min_max_sampler #(
		.MAX_BLOCKS(STORE_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.pixel (pix),
		.sample(smp)
	);

	// register mirror and block store
	logic [FACTOR_W-1:0] cfg_factor;
	mode_t               cfg_mode;
	kind_t               cfg_kind;
	logic [COORD_W-1:0]  cfg_left;
	logic [VALUE_W-1:0]  kept_value [STORE_DEPTH];
	logic [COORD_W-1:0]  kept_column [STORE_DEPTH];
	logic [COORD_W-1:0]  kept_row [STORE_DEPTH];
	logic                block_taken [STORE_DEPTH];

	pixel_t        pixel_backlog [$];
	block_sample_t pending_samples [$];
	int            mismatches;
	int            quiet_cycles;
	int            burst_left;
	int            gap_left;
	logic [15:0]   stall_mask;
	logic [3:0]    stall_pos;
	pixel_t        next_pixel;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [VALUE_W-1:0] rank_key(input logic [VALUE_W-1:0] v, input kind_t k);
		logic [31:0]        w;
		logic [VALUE_W-1:0] key;
		w = v[31:0];
		case (k)
			KIND_SINT: begin
				key = v ^ {1'b1, 63'd0};
			end
			KIND_COLOR: begin
				key = {32'd0, w};
			end
			KIND_F32: begin
				if (w[30:0] == 31'd0) key = {32'd0, 32'h8000_0000};
				else if (w[31]) key = {32'd0, ~w};
				else key = {32'd0, w | 32'h8000_0000};
			end
			default: begin
				if (v[62:0] == 63'd0) key = {1'b1, 63'd0};
				else if (v[63]) key = ~v;
				else key = v | {1'b1, 63'd0};
			end
		endcase
		return key;
	endfunction

	task automatic apply_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FACTOR: cfg_factor = data[FACTOR_W-1:0];
			REG_MODE:   cfg_mode = mode_t'(data[0]);
			REG_KIND:   cfg_kind = kind_t'(data[1:0]);
			default:    cfg_left = data[COORD_W-1:0];
		endcase
	endtask

	task automatic pool_pixel(input pixel_t p);
		logic [31:0]        f;
		logic [31:0]        origin;
		logic [31:0]        slot;
		logic [VALUE_W-1:0] v;
		logic               take;
		block_sample_t      s;
		int                 emitted;
		f = (cfg_factor == '0) ? 32'd1 : 32'(cfg_factor);
		origin = 32'(cfg_left) - (32'(cfg_left) % f);
		v = (cfg_kind == KIND_COLOR || cfg_kind == KIND_F32) ? {32'd0, p.value[31:0]} : p.value;
		if (32'(p.column) >= origin) begin
			slot = (32'(p.column) - origin) / f;
			if (slot < STORE_DEPTH) begin
				take = !block_taken[slot];
				if (!take) begin
					if (cfg_mode == MODE_MAX)
						take = rank_key(v, cfg_kind) > rank_key(kept_value[slot], cfg_kind);
					else
						take = rank_key(v, cfg_kind) < rank_key(kept_value[slot], cfg_kind);
				end
				if (take) begin
					kept_value[slot] = v;
					kept_column[slot] = p.column;
					kept_row[slot] = p.row;
					block_taken[slot] = 1'b1;
				end
			end
		end
		if (p.object_end || (p.row_end && ((32'(p.row) + 32'd1) % f) == 0)) begin
			emitted = 0;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				if (block_taken[i]) begin
					s.value = kept_value[i];
					s.column = kept_column[i];
					s.row = kept_row[i];
					s.last_of_run = 1'b0;
					pending_samples.push_back(s);
					emitted++;
				end
				block_taken[i] = 1'b0;
			end
			if (emitted > 0) pending_samples[pending_samples.size()-1].last_of_run = 1'b1;
		end
	endtask

	task automatic check_sample(input block_sample_t got);
		block_sample_t want;
		if (pending_samples.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("unexpected sample: value %h column %0d row %0d last %0b",
					got.value, got.column, got.row, got.last_of_run);
		end else begin
			want = pending_samples.pop_front();
			if (got.value !== want.value || got.column !== want.column ||
					got.row !== want.row || got.last_of_run !== want.last_of_run) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("sample mismatch: expected %h/%0d/%0d/%0b got %h/%0d/%0d/%0b",
						want.value, want.column, want.row, want.last_of_run,
						got.value, got.column, got.row, got.last_of_run);
			end
		end
	endtask

	// pixel sender: bursts and gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.column <= '0;
			pix.row <= '0;
			pix.pixel_value <= '0;
			pix.row_end <= 1'b0;
			pix.object_end <= 1'b0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!pix.valid || pix.ready) begin
			if (gap_left != 0 || pixel_backlog.size() == 0) begin
				pix.valid <= 1'b0;
				if (gap_left != 0) gap_left <= gap_left - 1;
			end else begin
				next_pixel = pixel_backlog.pop_front();
				pix.valid <= 1'b1;
				pix.column <= next_pixel.column;
				pix.row <= next_pixel.row;
				pix.pixel_value <= next_pixel.value;
				pix.row_end <= next_pixel.row_end;
				pix.object_end <= next_pixel.object_end;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// sample receiver: stall pattern reloaded at the end of each pass over the mask
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.ready <= 1'b0;
			stall_mask <= 16'hFFFF;
			stall_pos <= '0;
		end else begin
			smp.ready <= stall_mask[stall_pos];
			stall_pos <= stall_pos + 4'd1;
			if (stall_pos == 4'd15) begin
				case ($urandom_range(0, 3))
					0: stall_mask <= 16'hFFFF;
					1: stall_mask <= 16'($urandom) & 16'($urandom) | 16'h0100;
					2: stall_mask <= 16'($urandom) | 16'($urandom);
					default: stall_mask <= 16'($urandom) | 16'h0001;
				endcase
			end
		end
	end

	// transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) apply_write(reg_idx_t'(cfg.index), cfg.data);
			if (smp.valid && smp.ready)
				check_sample('{smp.sample_value, smp.sample_column, smp.sample_row,
					smp.last_of_run});
			if (pix.valid && pix.ready)
				pool_pixel('{pix.column, pix.row, pix.pixel_value, pix.row_end, pix.object_end});
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix.valid && pix.ready) || (smp.valid && smp.ready) || (cfg.valid && cfg.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("block_min_max_sampler regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic add_pixel(input logic [15:0] c, input logic [15:0] r,
			input logic [63:0] v, input logic re, input logic oe);
		pixel_t p;
		p.column = c;
		p.row = r;
		p.value = v;
		p.row_end = re;
		p.object_end = oe;
		pixel_backlog.push_back(p);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pixel_backlog.size() != 0 || pix.valid || pending_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic program_regs(input logic [8:0] f, input mode_t m, input kind_t k,
			input logic [15:0] l);
		reg_idx_t    idx [4];
		logic [15:0] vals [4];
		idx = '{REG_FACTOR, REG_MODE, REG_KIND, REG_LEFT};
		vals = '{{7'd0, f}, {15'd0, m}, {14'd0, k}, l};
		@(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data <= vals[i];
			do @(posedge clk);
			while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] draw_value(input kind_t k);
		logic [63:0] raw;
		int          pick;
		raw = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			// small pool so that equal values meet in one block
			if (k == KIND_COLOR || k == KIND_F32) raw[31:0] = 32'(pick);
			else raw = (pick == 2) ? '1 : 64'(pick);
		end else if (pick == 3) begin
			case (k)
				KIND_SINT: begin
					raw = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
				end
				KIND_COLOR: begin
					raw[31:0] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
				end
				KIND_F32: begin
					case ($urandom_range(0, 5))
						0: raw[31:0] = 32'h0000_0000;
						1: raw[31:0] = 32'h8000_0000;
						2: raw[31:0] = 32'h7F80_0000;
						3: raw[31:0] = 32'hFF80_0000;
						4: raw[31:0] = 32'h7FC0_0000;
						default: raw[31:0] = 32'hFFC0_0001;
					endcase
				end
				default: begin
					case ($urandom_range(0, 5))
						0: raw = 64'h0000_0000_0000_0000;
						1: raw = 64'h8000_0000_0000_0000;
						2: raw = 64'h7FF0_0000_0000_0000;
						3: raw = 64'hFFF0_0000_0000_0000;
						4: raw = 64'h7FF8_0000_0000_0000;
						default: raw = 64'hFFF8_0000_0000_0001;
					endcase
				end
			endcase
		end
		return raw;
	endfunction

	task automatic add_object(inout int made);
		int f;
		int w;
		int h;
		int r0;
		int c0;
		int cs;
		int ce;
		f = (cfg_factor == '0) ? 1 : int'(cfg_factor);
		h = $urandom_range(1, 6);
		w = $urandom_range(1, 12);
		if (f <= 2 && $urandom_range(0, 7) == 0) begin
			// wide enough to run past the block store
			h = 1;
			w = f * $urandom_range(62, 66);
		end
		r0 = $urandom_range(0, 65535);
		if ($urandom_range(0, 5) == 0) r0 = 65535 - $urandom_range(0, 3);
		c0 = int'(cfg_left) + $urandom_range(0, 2 * f);
		if ($urandom_range(0, 4) == 0) c0 = c0 - $urandom_range(1, 3);
		for (int r = 0; r < h; r++) begin
			cs = c0 + $urandom_range(0, 1);
			ce = cs + w - 1 - ((w > 2) ? $urandom_range(0, 1) : 0);
			for (int c = cs; c <= ce; c++) begin
				add_pixel(16'(c), 16'(r0 + r), draw_value(cfg_kind), c == ce,
					(r == h - 1) && (c == ce));
				made++;
			end
		end
	endtask

	function automatic logic [8:0] pick_factor();
		logic [8:0] f;
		case ($urandom_range(0, 9))
			0: f = 9'd0;
			1: f = 9'd1;
			2: f = 9'd2;
			3: f = 9'd3;
			4: f = 9'd4;
			5: f = 9'd8;
			6: f = 9'd256;
			7: f = 9'd511;
			8: f = 9'($urandom_range(5, 20));
			default: f = 9'($urandom_range(1, 511));
		endcase
		return f;
	endfunction

	function automatic logic [15:0] pick_left();
		logic [15:0] l;
		case ($urandom_range(0, 3))
			0: l = 16'd0;
			1: l = 16'hFFFF;
			2: l = 16'($urandom_range(0, 40));
			default: l = 16'($urandom);
		endcase
		return l;
	endfunction

	initial begin
		int made;
		int target;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_FACTOR;
		cfg.data = '0;
		cfg_factor = 9'd1;
		cfg_mode = MODE_MIN;
		cfg_kind = KIND_SINT;
		cfg_left = '0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			kept_value[i] = '0;
			kept_column[i] = '0;
			kept_row[i] = '0;
			block_taken[i] = 1'b0;
		end
		mismatches = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: extremes of signed order, equal value, empty flushes
		add_pixel(16'd0, 16'd0, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
		add_pixel(16'd1, 16'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
		add_pixel(16'd0, 16'd0, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
		add_pixel(16'hFFFF, 16'hFFFF, 64'h0, 1'b1, 1'b0);
		add_pixel(16'd63, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
		wait_drained();

		// float32 max near the top of the column range, signed zeros and nan
		program_regs(9'd4, MODE_MAX, KIND_F32, 16'hFFFF);
		add_pixel(16'd65531, 16'd7, 64'hDEAD_BEEF_3F80_0000, 1'b0, 1'b0);
		add_pixel(16'd65532, 16'd4, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0);
		add_pixel(16'd65533, 16'd5, 64'h0, 1'b0, 1'b0);
		add_pixel(16'd65534, 16'd6, 64'h1234_5678_FF80_0000, 1'b0, 1'b0);
		add_pixel(16'd65535, 16'd7, 64'h7F80_0000, 1'b1, 1'b0);
		add_pixel(16'd65535, 16'hFFFF, 64'h7FC0_0000, 1'b1, 1'b0);
		add_pixel(16'd65532, 16'd8, 64'hFFC0_0000, 1'b0, 1'b0);
		add_pixel(16'd65533, 16'd8, 64'hFF80_0000, 1'b0, 1'b1);
		wait_drained();

		// zero factor, colour min, last block column and one past it
		program_regs(9'd0, MODE_MIN, KIND_COLOR, 16'd0);
		add_pixel(16'd63, 16'd2, 64'hFFFF_FFFF_0000_0005, 1'b0, 1'b0);
		add_pixel(16'd64, 16'd2, 64'h1, 1'b0, 1'b0);
		add_pixel(16'd62, 16'd2, 64'h5, 1'b0, 1'b0);
		add_pixel(16'd63, 16'd3, 64'h0000_0007_0000_0005, 1'b0, 1'b0);
		add_pixel(16'd63, 16'd3, 64'h0, 1'b1, 1'b1);
		wait_drained();

		// factor of 256, float64 max, left of origin
		program_regs(9'd256, MODE_MAX, KIND_F64, 16'd300);
		add_pixel(16'd255, 16'd255, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
		add_pixel(16'd256, 16'd0, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
		add_pixel(16'd511, 16'd100, 64'h0, 1'b0, 1'b0);
		add_pixel(16'd512, 16'd255, 64'hFFF0_0000_0000_0000, 1'b1, 1'b0);
		wait_drained();

		// value kind switched while a block is open
		program_regs(9'd511, MODE_MIN, KIND_SINT, 16'd0);
		add_pixel(16'd5, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
		wait_drained();
		program_regs(9'd511, MODE_MIN, KIND_COLOR, 16'd0);
		add_pixel(16'd6, 16'd0, 64'h1, 1'b0, 1'b0);
		add_pixel(16'd510, 16'd510, 64'h2, 1'b1, 1'b0);

		made = 0;
		while (made < RANDOM_ITEMS) begin
			wait_drained();
			program_regs(pick_factor(), mode_t'($urandom_range(0, 1)),
				kind_t'($urandom_range(0, 3)), pick_left());
			target = made + $urandom_range(25, 55);
			while (made < target) begin
				if ($urandom_range(0, 6) == 0) begin
					add_pixel(16'($urandom), 16'($urandom), draw_value(cfg_kind),
						1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
					made++;
				end else begin
					add_object(made);
				end
			end
		end

		wait_drained();
		if (mismatches == 0 && pending_samples.size() == 0) begin
			$display("block_min_max_sampler regression: pass");
		end else begin
			$display("block_min_max_sampler regression: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
src/bmms_pkg.sv
src/bmms_if.sv
src/bmms_ram.sv
src/bmms_fifo.sv
src/bmms_front.sv
src/bmms_back.sv
src/block_min_max_sampler.sv
test/block_min_max_sampler_test.sv
